// File: rtl/core/yrd_pkg.sv
`timescale 1ns / 1ps

package yrd_pkg;

    localparam int VALUE_W    = 18;
    localparam int LABEL_W    = 7;
    localparam int COORD_W    = 16;
    localparam int SIZE_W     = 15;
    localparam int FRAME_W    = 14;
    localparam int THR_W      = 16;
    localparam int POS_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [POS_W-1:0] FIRST_CLASS_POS = POS_W'(5);
    localparam logic [POS_W-1:0] POS_SATURATED   = {POS_W{1'b1}};
    localparam logic [POS_W-1:0] NUM_BOX_FIELDS  = POS_W'(4);

    localparam logic [CFG_IDX_W-1:0] CFG_CONF_THRESHOLD = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT   = CFG_IDX_W'(2);

    localparam logic [THR_W-1:0]   THRESHOLD_RESET    = THR_W'(16384);
    localparam logic [FRAME_W-1:0] FRAME_WIDTH_RESET  = FRAME_W'(640);
    localparam logic [FRAME_W-1:0] FRAME_HEIGHT_RESET = FRAME_W'(480);

    typedef struct packed {
        logic [VALUE_W-1:0] element_value;
        logic               row_last;
    } t_element;

    typedef struct packed {
        logic [LABEL_W-1:0]        class_label;
        logic [VALUE_W-1:0]        best_score;
        logic signed [COORD_W-1:0] box_left;
        logic signed [COORD_W-1:0] box_top;
        logic [SIZE_W-1:0]         box_width;
        logic [SIZE_W-1:0]         box_height;
    } t_detection;

endpackage

// File: rtl/core/yrd_stream_if.sv
`timescale 1ns / 1ps

interface yrd_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/core/yolo_row_decode_argmax_unit.sv
`timescale 1ns / 1ps
// Path: a detection moves from the row's last element through the stage 1, stage 2 and output registers.
// Throughput: one element per cycle, rows back to back; a full output register that is not
// taken stalls the whole pipeline and drops input ready in the same cycle.
// Reset: synchronous, active low; clears the row state and all stage valids and loads the
// configuration registers with threshold 16384, frame 640 x 480.

module yolo_row_decode_argmax_unit #(
    parameter int MAX_CLASSES   = 128,
    parameter int FRACTION_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [yrd_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [yrd_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    yrd_stream_if.sink                        i_elem,
    yrd_stream_if.source                      o_det
);
    import yrd_pkg::*;

    // Product of an element and a frame size, and its scaled (shifted) width.
    localparam int PROD_W = VALUE_W + FRAME_W;
    localparam int SCL_W  = PROD_W - FRACTION_BITS;
    // Signed width wide enough for the corner subtraction and the clamp limits.
    localparam int EXT_W  = ((SCL_W > COORD_W) ? SCL_W : COORD_W) + 2;
    // Threshold compare: score << 16 against threshold << FRACTION_BITS.
    localparam int CMP_L  = VALUE_W + 16;
    localparam int CMP_R  = THR_W + FRACTION_BITS;
    localparam int CMP_W  = (CMP_L > CMP_R) ? CMP_L : CMP_R;

    localparam logic signed [EXT_W-1:0] SAT_MAX = EXT_W'(32767);
    localparam logic signed [EXT_W-1:0] SAT_MIN = ~SAT_MAX;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [THR_W-1:0]   r_threshold;
    logic [FRAME_W-1:0] r_frame_w;
    logic [FRAME_W-1:0] r_frame_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RESET;
            r_frame_w   <= FRAME_WIDTH_RESET;
            r_frame_h   <= FRAME_HEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CONF_THRESHOLD: r_threshold <= i_cfg_wdata[THR_W-1:0];
                CFG_FRAME_WIDTH:    r_frame_w   <= i_cfg_wdata[FRAME_W-1:0];
                CFG_FRAME_HEIGHT:   r_frame_h   <= i_cfg_wdata[FRAME_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline advance: every stage moves together while the output
    // register is empty or being emptied.
    // ------------------------------------------------------------------
    logic r_o_valid;
    logic adv;
    logic acc;

    assign adv          = !r_o_valid || o_det.ready;
    assign i_elem.ready = adv;
    assign acc          = i_elem.valid && adv;

    logic [VALUE_W-1:0] in_value;
    logic               in_last;
    assign in_value = i_elem.payload.element_value;
    assign in_last  = i_elem.payload.row_last;

    // ------------------------------------------------------------------
    // Row state: position, raw box fields and running argmax
    // ------------------------------------------------------------------
    logic [POS_W-1:0]   r_pos,   n_pos;
    logic [VALUE_W-1:0] r_box [4];
    logic [VALUE_W-1:0] n_box [4];
    logic [VALUE_W-1:0] r_best,  n_best;
    logic [LABEL_W-1:0] r_label, n_label;

    logic [POS_W-1:0]   cls_idx;
    logic               is_class;
    logic               emit;
    logic [CMP_W-1:0]   cmp_score;
    logic [CMP_W-1:0]   cmp_thr;

    assign cls_idx  = r_pos - FIRST_CLASS_POS;
    assign is_class = (r_pos >= FIRST_CLASS_POS) && (r_pos != POS_SATURATED)
                   && ({1'b0, cls_idx} < (POS_W + 1)'(MAX_CLASSES));

    always_comb begin
        n_box   = r_box;
        n_best  = r_best;
        n_label = r_label;
        if (r_pos < NUM_BOX_FIELDS) begin
            n_box[r_pos[1:0]] = in_value;
        end
        // First class always takes the slot; later ones must be strictly greater.
        if (is_class && (cls_idx == '0 || in_value > r_best)) begin
            n_best  = in_value;
            n_label = cls_idx[LABEL_W-1:0];
        end
        n_pos = (r_pos == POS_SATURATED) ? r_pos : r_pos + POS_W'(1);
    end

    assign cmp_score = CMP_W'({n_best, 16'b0});
    assign cmp_thr   = CMP_W'({r_threshold, {FRACTION_BITS{1'b0}}});
    // A row needs at least six elements: the last one sits at position five or later.
    assign emit      = (r_pos >= FIRST_CLASS_POS) && (cmp_score > cmp_thr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_best  <= '0;
            r_label <= '0;
            for (int k = 0; k < 4; k++) begin
                r_box[k] <= '0;
            end
        end else if (acc) begin
            if (in_last) begin
                // Drop the row state whether or not a detection leaves.
                r_pos   <= '0;
                r_best  <= '0;
                r_label <= '0;
                for (int k = 0; k < 4; k++) begin
                    r_box[k] <= '0;
                end
            end else begin
                r_pos   <= n_pos;
                r_best  <= n_best;
                r_label <= n_label;
                r_box   <= n_box;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: captured row result waiting for scaling
    // ------------------------------------------------------------------
    logic               r_j_valid;
    logic [VALUE_W-1:0] r_j_box [4];
    logic [VALUE_W-1:0] r_j_score;
    logic [LABEL_W-1:0] r_j_label;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_j_valid <= 1'b0;
        end else if (adv) begin
            r_j_valid <= acc && in_last && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && acc && in_last) begin
            r_j_box   <= n_box;
            r_j_score <= n_best;
            r_j_label <= n_label;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: scale to the frame, one multiplier per coordinate
    // ------------------------------------------------------------------
    logic              r_p_valid;
    logic [SCL_W-1:0]  r_p_cx, r_p_cy, r_p_w, r_p_h;
    logic [VALUE_W-1:0] r_p_score;
    logic [LABEL_W-1:0] r_p_label;
    logic [PROD_W-1:0] prod_cx, prod_cy, prod_w, prod_h;

    assign prod_cx = PROD_W'(r_j_box[0]) * PROD_W'(r_frame_w);
    assign prod_cy = PROD_W'(r_j_box[1]) * PROD_W'(r_frame_h);
    assign prod_w  = PROD_W'(r_j_box[2]) * PROD_W'(r_frame_w);
    assign prod_h  = PROD_W'(r_j_box[3]) * PROD_W'(r_frame_h);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (adv) begin
            r_p_valid <= r_j_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p_cx    <= prod_cx[PROD_W-1:FRACTION_BITS];
            r_p_cy    <= prod_cy[PROD_W-1:FRACTION_BITS];
            r_p_w     <= prod_w[PROD_W-1:FRACTION_BITS];
            r_p_h     <= prod_h[PROD_W-1:FRACTION_BITS];
            r_p_score <= r_j_score;
            r_p_label <= r_j_label;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: corner subtraction, saturation and output register
    // ------------------------------------------------------------------
    logic signed [EXT_W-1:0] ext_cx, ext_cy, ext_w, ext_h;
    logic signed [EXT_W-1:0] raw_left, raw_top;
    logic signed [EXT_W-1:0] sat_left, sat_top, sat_w, sat_h;
    t_detection              r_o_det;

    assign ext_cx   = $signed(EXT_W'(r_p_cx));
    assign ext_cy   = $signed(EXT_W'(r_p_cy));
    assign ext_w    = $signed(EXT_W'(r_p_w));
    assign ext_h    = $signed(EXT_W'(r_p_h));
    assign raw_left = ext_cx - $signed(EXT_W'(r_p_w >> 1));
    assign raw_top  = ext_cy - $signed(EXT_W'(r_p_h >> 1));

    always_comb begin
        sat_left = raw_left;
        if (raw_left > SAT_MAX) sat_left = SAT_MAX;
        else if (raw_left < SAT_MIN) sat_left = SAT_MIN;
        sat_top = raw_top;
        if (raw_top > SAT_MAX) sat_top = SAT_MAX;
        else if (raw_top < SAT_MIN) sat_top = SAT_MIN;
        sat_w = (ext_w > SAT_MAX) ? SAT_MAX : ext_w;
        sat_h = (ext_h > SAT_MAX) ? SAT_MAX : ext_h;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (adv) begin
            r_o_valid <= r_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_o_det.class_label <= r_p_label;
            r_o_det.best_score  <= r_p_score;
            r_o_det.box_left    <= sat_left[COORD_W-1:0];
            r_o_det.box_top     <= sat_top[COORD_W-1:0];
            r_o_det.box_width   <= sat_w[SIZE_W-1:0];
            r_o_det.box_height  <= sat_h[SIZE_W-1:0];
        end
    end

    assign o_det.valid   = r_o_valid;
    assign o_det.payload = r_o_det;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_row_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && in_last) |=> (r_pos == '0 && r_best == '0))
        else $error("row state not cleared after last element");

    a_first_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && !in_last && r_pos == FIRST_CLASS_POS) |=> (r_best == $past(in_value)))
        else $error("first class score not taken");

    a_job_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && !(acc && in_last)) |=> !r_j_valid)
        else $error("detection started without a row end");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !adv) |=> (r_o_valid && $stable(r_o_det) && $stable(r_p_valid)))
        else $error("pipeline moved while stalled");

endmodule
